// ===== hw/rtl/rsd_pkg.sv =====
// Shared types and constants for the row z-score ternary discretizer.
// Used by rsd_iter and row_sd_ternary_discretizer; no dependencies.
`timescale 1ns / 1ps
package rsd_pkg;

  localparam int unsigned OP_W       = 64;
  localparam int unsigned DIV_STEPS  = 64;
  localparam int unsigned SQRT_STEPS = 32;

  localparam logic REG_MULT_LOWER = 1'b0;
  localparam logic REG_MULT_UPPER = 1'b1;

  localparam logic [1:0] CLS_LOW  = 2'b11;
  localparam logic [1:0] CLS_MID  = 2'b00;
  localparam logic [1:0] CLS_HIGH = 2'b01;

  typedef struct packed {
    logic start;
    logic sqrt_op;
  } iter_req_t;

  // Clamp a 42-bit signed value into the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [41:0] v);
    logic [31:0] r;
    if (v > 42'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -42'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/rsd_iter.sv =====
// Shared iterative unit: restoring 64-bit unsigned divide or integer square root.
// One subtract-and-compare per cycle. Uses rsd_pkg.
`timescale 1ns / 1ps
module rsd_iter (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rsd_pkg::iter_req_t    req_i,
  input  logic [63:0]           a_i,
  input  logic [63:0]           b_i,
  output logic                  done_o,
  output logic [63:0]           res_o,
  output logic                  rem_nz_o
);

  logic [65:0] acc_q, acc_d;
  logic [63:0] work_q, work_d;
  logic [63:0] div_q;
  logic [31:0] root_q, root_d;
  logic [6:0]  cnt_q;
  logic        busy_q, op_q, done_q;
  logic [65:0] shifted, operand;
  logic [66:0] diff;
  logic        ge;

  always_comb begin
    if (op_q) begin
      shifted = {acc_q[63:0], work_q[63:62]};
      operand = {32'b0, root_q, 2'b01};
    end else begin
      shifted = {acc_q[64:0], work_q[63]};
      operand = {2'b0, div_q};
    end
    diff  = {1'b0, shifted} - {1'b0, operand};
    ge    = ~diff[66];
    acc_d = ge ? diff[65:0] : shifted;
    if (op_q) begin
      work_d = {work_q[61:0], 2'b00};
      root_d = {root_q[30:0], ge};
    end else begin
      work_d = {work_q[62:0], ge};
      root_d = root_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.sqrt_op;
        cnt_q  <= req_i.sqrt_op ? 7'(rsd_pkg::SQRT_STEPS) : 7'(rsd_pkg::DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q  <= '0;
      work_q <= a_i;
      div_q  <= b_i;
      root_q <= '0;
    end else if (busy_q) begin
      acc_q  <= acc_d;
      work_q <= work_d;
      root_q <= root_d;
    end
  end

  assign done_o   = done_q;
  assign res_o    = op_q ? {32'b0, root_q} : work_q;
  assign rem_nz_o = |acc_q;

endmodule

// ===== hw/rtl/row_sd_ternary_discretizer.sv =====
// Row z-score ternary discretizer, top level. Uses rsd_pkg and rsd_iter.
// Samples load one per cycle while in_stall_o is low. On the row's last sample the block
// computes the mean (divide), a variance pass per stored sample (read, subtract, square,
// accumulate), a divide, a square root and the threshold steps, then emits one class per
// stored sample (read, load, output); all division and root steps share the rsd_iter unit.
// Reset clears the row counters and sets both multipliers to 1.0 (Q8.8 256).
`timescale 1ns / 1ps
module row_sd_ternary_discretizer #(
  parameter int unsigned ROW_LEN = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] sample_value_i,
  input  logic        sample_missing_i,
  input  logic        last_in_row_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  class_out_o,
  output logic [31:0] lower_threshold_o,
  output logic [31:0] upper_threshold_o,
  output logic        last_out_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned AW    = (ROW_LEN > 1) ? $clog2(ROW_LEN) : 1;
  localparam int unsigned CW    = $clog2(ROW_LEN + 1);
  localparam int unsigned SUM_W = 33 + AW;

  localparam logic [3:0] S_LOAD     = 4'd0;
  localparam logic [3:0] S_MEAN_GO  = 4'd1;
  localparam logic [3:0] S_MEAN_WT  = 4'd2;
  localparam logic [3:0] S_VAR_INIT = 4'd3;
  localparam logic [3:0] S_VAR_RD   = 4'd4;
  localparam logic [3:0] S_VAR_SUB  = 4'd5;
  localparam logic [3:0] S_VAR_MUL  = 4'd6;
  localparam logic [3:0] S_VAR_ACC  = 4'd7;
  localparam logic [3:0] S_VAR_WT   = 4'd8;
  localparam logic [3:0] S_SQRT_WT  = 4'd9;
  localparam logic [3:0] S_THL      = 4'd10;
  localparam logic [3:0] S_THU      = 4'd11;
  localparam logic [3:0] S_THFIX    = 4'd12;
  localparam logic [3:0] S_EMIT_RD  = 4'd13;
  localparam logic [3:0] S_EMIT_LD  = 4'd14;
  localparam logic [3:0] S_EMIT_OUT = 4'd15;

  logic [3:0]       state_q;
  logic [CW-1:0]    row_cnt_q, vcnt_q, idx_q;
  logic [SUM_W-1:0] sum_q;
  logic [15:0]      mult_lo_q, mult_hi_q;
  logic [31:0]      mean_q, sd_q, lo_q, hi_q;
  logic [63:0]      sumsq_q;
  logic [32:0]      ad_q;
  logic [65:0]      prod_q;
  logic             miss_q;

  logic [32:0]      mem [ROW_LEN];
  logic [32:0]      rd_q;

  logic             in_acc, out_acc;
  logic [1:0]       cls_q;
  logic             out_valid_q, last_q;

  rsd_pkg::iter_req_t req;
  logic [63:0]      it_a, it_b, it_res;
  logic             it_done, it_rem_nz;

  logic [SUM_W-1:0] sum_abs;
  logic [32:0]      mean_neg;
  logic signed [32:0] dev;
  logic signed [41:0] th_lo, th_hi;
  logic [31:0]      hi_sat;

  assign in_stall_o = (state_q != S_LOAD);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_acc    = out_valid_q & ~out_stall_i;

  assign sum_abs  = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
  assign mean_neg = ~({1'b0, it_res[31:0]} + {32'b0, it_rem_nz}) + 33'd1;
  assign dev      = $signed({rd_q[31], rd_q[31:0]}) - $signed({mean_q[31], mean_q});
  assign th_lo    = $signed({{10{mean_q[31]}}, mean_q}) - $signed({2'b0, prod_q[47:8]});
  assign th_hi    = $signed({{10{mean_q[31]}}, mean_q}) + $signed({2'b0, prod_q[47:8]});
  assign hi_sat   = rsd_pkg::sat32(th_hi);

  always_comb begin
    req.start   = 1'b0;
    req.sqrt_op = 1'b0;
    it_a        = {{(64 - SUM_W){1'b0}}, sum_abs};
    it_b        = {{(64 - CW){1'b0}}, vcnt_q};
    unique case (state_q)
      S_MEAN_GO: begin
        req.start = (vcnt_q != '0);
      end
      S_VAR_INIT: begin
        req.start = (vcnt_q < CW'(2));
        req.sqrt_op = 1'b1;
        it_a = '0;
      end
      S_VAR_ACC: begin
        req.start = (idx_q + CW'(1) == row_cnt_q);
        it_a = sumsq_q + (miss_q ? 64'd0 : {14'b0, prod_q[65:16]});
        it_b = {{(64 - CW){1'b0}}, vcnt_q - CW'(1)};
      end
      S_VAR_WT: begin
        req.start   = it_done;
        req.sqrt_op = 1'b1;
        it_a = (|it_res[63:48]) ? {48'hffff_ffff_ffff, 16'b0} : {it_res[47:0], 16'b0};
      end
      default: begin
      end
    endcase
  end

  rsd_iter u_iter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .a_i      (it_a),
    .b_i      (it_b),
    .done_o   (it_done),
    .res_o    (it_res),
    .rem_nz_o (it_rem_nz)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc && (row_cnt_q < CW'(ROW_LEN))) begin
      mem[row_cnt_q[AW-1:0]] <= {sample_missing_i, sample_value_i};
    end
    rd_q <= mem[idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_lo_q <= 16'd256;
      mult_hi_q <= 16'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rsd_pkg::REG_MULT_LOWER: mult_lo_q <= cfg_data_i;
        rsd_pkg::REG_MULT_UPPER: mult_hi_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      row_cnt_q   <= '0;
      vcnt_q      <= '0;
      sum_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      mean_q      <= '0;
      sd_q        <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      sumsq_q     <= '0;
      ad_q        <= '0;
      prod_q      <= '0;
      miss_q      <= 1'b0;
      cls_q       <= rsd_pkg::CLS_MID;
      last_q      <= 1'b0;
    end else begin
      unique case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            if (row_cnt_q < CW'(ROW_LEN)) begin
              row_cnt_q <= row_cnt_q + CW'(1);
              if (!sample_missing_i) begin
                vcnt_q <= vcnt_q + CW'(1);
                sum_q  <= sum_q + {{(SUM_W - 32){sample_value_i[31]}}, sample_value_i};
              end
            end
            if (last_in_row_i) begin
              state_q <= S_MEAN_GO;
            end
          end
        end
        S_MEAN_GO: begin
          if (vcnt_q == '0) begin
            mean_q  <= '0;
            state_q <= S_VAR_INIT;
          end else begin
            state_q <= S_MEAN_WT;
          end
        end
        S_MEAN_WT: begin
          if (it_done) begin
            mean_q  <= sum_q[SUM_W-1] ? mean_neg[31:0] : it_res[31:0];
            state_q <= S_VAR_INIT;
          end
        end
        S_VAR_INIT: begin
          sumsq_q <= '0;
          idx_q   <= '0;
          // With fewer than two valid samples the variance is zero; the root runs on zero.
          if (vcnt_q < CW'(2)) begin
            state_q <= S_SQRT_WT;
          end else begin
            state_q <= S_VAR_RD;
          end
        end
        S_VAR_RD: begin
          state_q <= S_VAR_SUB;
        end
        S_VAR_SUB: begin
          ad_q    <= dev[32] ? 33'(-dev) : 33'(dev);
          miss_q  <= rd_q[32];
          state_q <= S_VAR_MUL;
        end
        S_VAR_MUL: begin
          prod_q  <= ad_q * ad_q;
          state_q <= S_VAR_ACC;
        end
        S_VAR_ACC: begin
          sumsq_q <= it_a;
          if (idx_q + CW'(1) == row_cnt_q) begin
            state_q <= S_VAR_WT;
          end else begin
            idx_q   <= idx_q + CW'(1);
            state_q <= S_VAR_RD;
          end
        end
        S_VAR_WT: begin
          if (it_done) begin
            state_q <= S_SQRT_WT;
          end
        end
        S_SQRT_WT: begin
          if (it_done) begin
            sd_q    <= it_res[31:0];
            state_q <= S_THL;
          end
        end
        S_THL: begin
          prod_q  <= 66'(sd_q * mult_lo_q);
          state_q <= S_THU;
        end
        S_THU: begin
          lo_q    <= rsd_pkg::sat32(th_lo);
          prod_q  <= 66'(sd_q * mult_hi_q);
          state_q <= S_THFIX;
        end
        S_THFIX: begin
          // A zero multiplier collapses both cutoffs onto the other one.
          priority if (mult_lo_q == '0) begin
            lo_q <= hi_sat;
            hi_q <= hi_sat;
          end else if (mult_hi_q == '0) begin
            hi_q <= lo_q;
          end else begin
            hi_q <= hi_sat;
          end
          idx_q   <= '0;
          state_q <= S_EMIT_RD;
        end
        S_EMIT_RD: begin
          state_q <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          out_valid_q <= 1'b1;
          last_q      <= (idx_q + CW'(1) == row_cnt_q);
          priority if (rd_q[32]) begin
            cls_q <= rsd_pkg::CLS_MID;
          end else if ($signed(rd_q[31:0]) <= $signed(lo_q)) begin
            cls_q <= rsd_pkg::CLS_LOW;
          end else if ($signed(rd_q[31:0]) >= $signed(hi_q)) begin
            cls_q <= rsd_pkg::CLS_HIGH;
          end else begin
            cls_q <= rsd_pkg::CLS_MID;
          end
          state_q <= S_EMIT_OUT;
        end
        S_EMIT_OUT: begin
          if (out_acc) begin
            out_valid_q <= 1'b0;
            if (last_q) begin
              row_cnt_q <= '0;
              vcnt_q    <= '0;
              sum_q     <= '0;
              idx_q     <= '0;
              state_q   <= S_LOAD;
            end else begin
              idx_q   <= idx_q + CW'(1);
              state_q <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign class_out_o       = cls_q;
  assign lower_threshold_o = lo_q;
  assign upper_threshold_o = hi_q;
  assign last_out_o        = last_q;

endmodule
